FILE: hw/rtl/cptlc_pkg.sv
package cptlc_pkg;

   localparam int WordWidth = 16;
   localparam int NibWidth  = 4;
   localparam int NibCount  = WordWidth / NibWidth;

   localparam logic [WordWidth-1:0] KeyAllOnes = 16'hFFFF;
   localparam logic [WordWidth-1:0] KeyZero    = 16'h0000;

   typedef logic [WordWidth-1:0] word_type;
   typedef logic [NibWidth-1:0]  nib_type;

   // nibble permutation codes of the working key derivation
   localparam logic [2:0] PermKeep   = 3'd0;
   localparam logic [2:0] PermSw01   = 3'd1;
   localparam logic [2:0] PermSw02   = 3'd2;
   localparam logic [2:0] PermSw03   = 3'd3;
   localparam logic [2:0] PermSw0123 = 3'd4;
   localparam logic [2:0] PermSw0213 = 3'd5;
   localparam logic [2:0] PermSw0312 = 3'd6;
   localparam logic [2:0] PermRotUp  = 3'd7;

   // one pipeline stage: a transaction plus the key of the layer it meets next
   typedef struct packed {
      logic     valid;
      logic     decrypt;
      word_type value;
      word_type index;
      word_type dkey;
      word_type wk;
      logic     on;
   } stage_type;

   function automatic logic key_active(input word_type k);
      return (k != KeyZero) && (k != KeyAllOnes);
   endfunction

   function automatic word_type derive_key(input word_type key);
      nib_type    n0, n1, n2, n3;
      nib_type    m0, m1, m2, m3;
      logic [2:0] sel;
      n0 = key[3:0];
      n1 = key[7:4];
      n2 = key[11:8];
      n3 = key[15:12];
      sel = {n2[2], n1[1], n0[0]};
      m0 = n0; m1 = n1; m2 = n2; m3 = n3;
      case (sel)
         PermKeep: begin
         end
         PermSw01: begin
            m0 = n1; m1 = n0;
         end
         PermSw02: begin
            m0 = n2; m2 = n0;
         end
         PermSw03: begin
            m0 = n3; m3 = n0;
         end
         PermSw0123: begin
            m0 = n1; m1 = n0; m2 = n3; m3 = n2;
         end
         PermSw0213: begin
            m0 = n2; m2 = n0; m1 = n3; m3 = n1;
         end
         PermSw0312: begin
            m0 = n3; m3 = n0; m1 = n2; m2 = n1;
         end
         PermRotUp: begin
            m0 = n3; m1 = n0; m2 = n1; m3 = n2;
         end
         default: begin
         end
      endcase
      return {~m3, m2, m1, m0};
   endfunction

   function automatic word_type xor_bytes(input word_type w, input word_type wk);
      return w ^ {wk[15:8], wk[15:8]};
   endfunction

   function automatic word_type enc_word(input word_type w, input word_type wk);
      word_type                r;
      logic [2*WordWidth-1:0]  t;
      for (int i = 0; i < NibCount; i++) begin
         r[i*NibWidth +: NibWidth] = w[i*NibWidth +: NibWidth] + wk[3:0]
                                     + NibWidth'(i);
      end
      t = {r, r} << wk[7:4];
      return xor_bytes(t[2*WordWidth-1:WordWidth], wk);
   endfunction

   function automatic word_type dec_word(input word_type w, input word_type wk);
      word_type                x;
      word_type                r;
      logic [2*WordWidth-1:0]  t;
      x = xor_bytes(w, wk);
      t = {x, x} >> wk[7:4];
      for (int i = 0; i < NibCount; i++) begin
         r[i*NibWidth +: NibWidth] = t[i*NibWidth +: NibWidth] - wk[3:0]
                                     - NibWidth'(i);
      end
      return r;
   endfunction

endpackage

FILE: hw/rtl/can_payload_two_layer_cipher_core.sv
// Two-layer word cipher for a three-word CAN payload, as a four-stage pipeline.
// A transaction on req_ carries the operation bit and the value, index and data
// key words; one transaction on rsp_ returns the three transformed words, in
// order. One transaction can enter every cycle unless all stages are full and
// rsp_ready is low; each stage holds its item only while the stage after it is
// full and stalled, so a waiting result does not block entry into empty stages.
// Stages: 1 registers the frame with the working key of the first layer,
// 2 applies the first layer, 3 derives the working key of the second layer,
// 4 applies the second layer and is the output register. Encryption runs the
// data-key layer on value and index, then the system-key layer on all three
// words; decryption runs the system-key inverse first, then the data-key inverse
// with the recovered key. csr_system_key is always ready; its working key is
// derived at write time. Write it only while the pipeline is empty. A key of
// 0 or 0xFFFF disables its layer.
module can_payload_two_layer_cipher_core
   import cptlc_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 csr_valid,
   output logic                 csr_ready,
   input  logic [WordWidth-1:0] csr_system_key,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  logic                 req_operation,
   input  logic [WordWidth-1:0] req_value_word,
   input  logic [WordWidth-1:0] req_index_word,
   input  logic [WordWidth-1:0] req_data_key_word,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output logic [WordWidth-1:0] rsp_out_value,
   output logic [WordWidth-1:0] rsp_out_index,
   output logic [WordWidth-1:0] rsp_out_data_key
);

   // system key, held as its working key plus layer enable
   word_type  sys_wk_ff;
   logic      sys_on_ff;

   stage_type s1_ff, s1_in;
   stage_type s2_ff, s2_in;
   stage_type s3_ff, s3_in;
   stage_type s4_ff, s4_in;

   logic adv1, adv2, adv3, adv4;

   // a stage loads when it is empty or its item moves on
   assign adv4 = !s4_ff.valid || rsp_ready;
   assign adv3 = !s3_ff.valid || adv4;
   assign adv2 = !s2_ff.valid || adv3;
   assign adv1 = !s1_ff.valid || adv2;

   assign csr_ready = 1'b1;
   assign req_ready = adv1;

   always_ff @(posedge clock) begin
      if (reset) begin
         sys_on_ff <= 1'b0;
      end else if (csr_valid) begin
         sys_on_ff <= key_active(csr_system_key);
      end
   end

   always_ff @(posedge clock) begin
      if (csr_valid) begin
         sys_wk_ff <= derive_key(csr_system_key);
      end
   end

   // stage 1: capture, pick first-layer key
   always_comb begin
      s1_in         = s1_ff;
      s1_in.valid   = req_valid;
      s1_in.decrypt = req_operation;
      s1_in.value   = req_value_word;
      s1_in.index   = req_index_word;
      s1_in.dkey    = req_data_key_word;
      if (req_operation) begin
         s1_in.wk = sys_wk_ff;
         s1_in.on = sys_on_ff;
      end else begin
         s1_in.wk = derive_key(req_data_key_word);
         s1_in.on = key_active(req_data_key_word);
      end
   end

   // stage 2: first layer
   always_comb begin
      s2_in = s1_ff;
      if (s1_ff.on) begin
         if (s1_ff.decrypt) begin
            s2_in.value = dec_word(s1_ff.value, s1_ff.wk);
            s2_in.index = dec_word(s1_ff.index, s1_ff.wk);
            s2_in.dkey  = dec_word(s1_ff.dkey, s1_ff.wk);
         end else begin
            s2_in.value = enc_word(s1_ff.value, s1_ff.wk);
            s2_in.index = enc_word(s1_ff.index, s1_ff.wk);
         end
      end
   end

   // stage 3: second-layer key; decrypt uses the recovered data key
   always_comb begin
      s3_in = s2_ff;
      if (s2_ff.decrypt) begin
         s3_in.wk = derive_key(s2_ff.dkey);
         s3_in.on = key_active(s2_ff.dkey);
      end else begin
         s3_in.wk = sys_wk_ff;
         s3_in.on = sys_on_ff;
      end
   end

   // stage 4: second layer
   always_comb begin
      s4_in = s3_ff;
      if (s3_ff.on) begin
         if (s3_ff.decrypt) begin
            s4_in.index = dec_word(s3_ff.index, s3_ff.wk);
            s4_in.value = dec_word(s3_ff.value, s3_ff.wk);
         end else begin
            s4_in.value = enc_word(s3_ff.value, s3_ff.wk);
            s4_in.index = enc_word(s3_ff.index, s3_ff.wk);
            s4_in.dkey  = enc_word(s3_ff.dkey, s3_ff.wk);
         end
      end
   end

   // valid bits reset; payload fields load on advance with no reset
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_ff.valid <= 1'b0;
         s2_ff.valid <= 1'b0;
         s3_ff.valid <= 1'b0;
         s4_ff.valid <= 1'b0;
      end else begin
         if (adv1) s1_ff.valid <= s1_in.valid;
         if (adv2) s2_ff.valid <= s2_in.valid;
         if (adv3) s3_ff.valid <= s3_in.valid;
         if (adv4) s4_ff.valid <= s4_in.valid;
      end
      if (adv1) begin
         s1_ff.decrypt <= s1_in.decrypt;
         s1_ff.value   <= s1_in.value;
         s1_ff.index   <= s1_in.index;
         s1_ff.dkey    <= s1_in.dkey;
         s1_ff.wk      <= s1_in.wk;
         s1_ff.on      <= s1_in.on;
      end
      if (adv2) begin
         s2_ff.decrypt <= s2_in.decrypt;
         s2_ff.value   <= s2_in.value;
         s2_ff.index   <= s2_in.index;
         s2_ff.dkey    <= s2_in.dkey;
         s2_ff.wk      <= s2_in.wk;
         s2_ff.on      <= s2_in.on;
      end
      if (adv3) begin
         s3_ff.decrypt <= s3_in.decrypt;
         s3_ff.value   <= s3_in.value;
         s3_ff.index   <= s3_in.index;
         s3_ff.dkey    <= s3_in.dkey;
         s3_ff.wk      <= s3_in.wk;
         s3_ff.on      <= s3_in.on;
      end
      if (adv4) begin
         s4_ff.decrypt <= s4_in.decrypt;
         s4_ff.value   <= s4_in.value;
         s4_ff.index   <= s4_in.index;
         s4_ff.dkey    <= s4_in.dkey;
         s4_ff.wk      <= s4_in.wk;
         s4_ff.on      <= s4_in.on;
      end
   end

   assign rsp_valid        = s4_ff.valid;
   assign rsp_out_value    = s4_ff.value;
   assign rsp_out_index    = s4_ff.index;
   assign rsp_out_data_key = s4_ff.dkey;

   // a stalled stage 1 item is never dropped
   a_s1_hold: assert property (@(posedge clock) disable iff (reset)
      s1_ff.valid && !adv2 |=> s1_ff.valid)
      else $error("stage 1 item lost while stalled");

   // a disabled first layer passes the words through unchanged
   a_l1_bypass: assert property (@(posedge clock) disable iff (reset)
      s1_ff.valid && !s1_ff.on && adv2 |=>
         s2_ff.value == $past(s1_ff.value) && s2_ff.index == $past(s1_ff.index)
         && s2_ff.dkey == $past(s1_ff.dkey))
      else $error("disabled layer changed the payload");

   // encryption never alters the data key in the first layer
   a_l1_dkey: assert property (@(posedge clock) disable iff (reset)
      s1_ff.valid && !s1_ff.decrypt && adv2 |=> s2_ff.dkey == $past(s1_ff.dkey))
      else $error("data key altered by the data-key layer");

   // nothing is presented right after reset
   a_reset_empty: assert property (@(posedge clock)
      $past(reset) |-> !rsp_valid)
      else $error("result valid right after reset");

endmodule
